>>> rtl/sco_pkg.sv
// Shared widths and types for the sphere/capsule overlap pipeline.
package sco_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_AXES   = 3;
    localparam int RAD_W      = 15;
    localparam int RSUM_W     = RAD_W + 1;
    localparam int RR_W       = 2 * RSUM_W;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 1;
    // holds ww - rr, ww - 2t + l2 and 2t without overflow
    localparam int EXT_W      = ((DOT_W > RR_W) ? DOT_W : (RR_W + 1)) + 1;
    localparam int MUL_W      = EXT_W - 1;
    localparam int LO_W       = (MUL_W + 1) / 2;
    localparam int HI_W       = MUL_W - LO_W;
    localparam int P_W        = 2 * MUL_W;

    typedef struct packed {
        logic pp;   // partial product stage advances
        logic sum;  // partial sum stage advances
    } sco_en_t;

endpackage

>>> rtl/sco_wide_mul.sv
// Two-stage unsigned MUL_W x MUL_W multiplier built from half-width partial products.
module sco_wide_mul
    import sco_pkg::*;
(
    input  logic             aclk,
    input  sco_en_t          en,
    input  logic [MUL_W-1:0] a,
    input  logic [MUL_W-1:0] b,
    output logic [P_W-1:0]   p
);

    logic [2*LO_W-1:0]      ll_reg;
    logic [LO_W+HI_W-1:0]   lh_reg;
    logic [LO_W+HI_W-1:0]   hl_reg;
    logic [2*HI_W-1:0]      hh_reg;
    logic [P_W-1:0]         p_reg;
    logic [LO_W+HI_W:0]     mid_next;
    logic [P_W-1:0]         p_next;

    always_ff @(posedge aclk) begin
        if (en.pp) begin
            ll_reg <= a[LO_W-1:0] * b[LO_W-1:0];
            lh_reg <= a[LO_W-1:0] * b[MUL_W-1:LO_W];
            hl_reg <= a[MUL_W-1:LO_W] * b[LO_W-1:0];
            hh_reg <= a[MUL_W-1:LO_W] * b[MUL_W-1:LO_W];
        end
    end

    always_comb begin
        mid_next = (LO_W+HI_W+1)'(lh_reg) + (LO_W+HI_W+1)'(hl_reg);
        p_next   = {hh_reg, ll_reg} + (P_W'(mid_next) << LO_W);
    end

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/sphere_capsule_overlap_test.sv
// Sphere versus capsule overlap test, exact fixed point, seven register stages.
// Throughput: one item per cycle when the output is not stalled; the 35x35 cross
// products are split over two stages.
// Each stage holds its item on stall while earlier empty stages keep filling.
// aresetn (synchronous, active low) clears all stage valid bits; data is not reset.
module sphere_capsule_overlap_test
    import sco_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_sphere_x,
    input  logic signed [COORD_BITS-1:0] s_sphere_y,
    input  logic signed [COORD_BITS-1:0] s_sphere_z,
    input  logic        [RAD_W-1:0]      s_sphere_radius,
    input  logic signed [COORD_BITS-1:0] s_seg_start_x,
    input  logic signed [COORD_BITS-1:0] s_seg_start_y,
    input  logic signed [COORD_BITS-1:0] s_seg_start_z,
    input  logic signed [COORD_BITS-1:0] s_seg_end_x,
    input  logic signed [COORD_BITS-1:0] s_seg_end_y,
    input  logic signed [COORD_BITS-1:0] s_seg_end_z,
    input  logic        [RAD_W-1:0]      s_capsule_radius,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_overlap
);

    // stage control
    logic [7:1] vld_reg;
    logic [7:1] vld_next;
    logic [7:1] rdy;

    // stage 1: differences
    logic signed [COORD_BITS-1:0] ctr   [NUM_AXES];
    logic signed [COORD_BITS-1:0] start [NUM_AXES];
    logic signed [COORD_BITS-1:0] stop  [NUM_AXES];
    logic signed [DIFF_W-1:0]     d_reg [NUM_AXES];
    logic signed [DIFF_W-1:0]     w_reg [NUM_AXES];
    logic        [RSUM_W-1:0]     rsum_reg;

    // stage 2: products
    logic signed [PROD_W-1:0] dd_reg [NUM_AXES];
    logic signed [PROD_W-1:0] wd_reg [NUM_AXES];
    logic signed [PROD_W-1:0] ww_reg [NUM_AXES];
    logic        [RR_W-1:0]   rr_reg;

    // stage 3: dot products
    logic signed [DOT_W-1:0] l2_reg;
    logic signed [DOT_W-1:0] t_reg;
    logic signed [DOT_W-1:0] wsq_reg;
    logic        [RR_W-1:0]  rr3_reg;

    // stage 4: case flags and reduced terms
    logic signed [EXT_W-1:0] wsq_ext;
    logic signed [EXT_W-1:0] rr_ext;
    logic signed [EXT_W-1:0] t_ext;
    logic signed [EXT_W-1:0] l2_ext;
    logic signed [EXT_W-1:0] g_next;
    logic signed [EXT_W-1:0] ff_next;
    logic signed [EXT_W-1:0] g_reg;
    logic signed [EXT_W-1:0] ff_reg;
    logic signed [EXT_W-1:0] rr4_reg;
    logic signed [DOT_W-1:0] l2_4_reg;
    logic signed [DOT_W-1:0] t4_reg;
    logic                    t_le0_reg;
    logic                    t_ge_reg;

    // stages 5..7: endpoint decision and interior cross-product compare
    logic             g_le0;
    logic             decided_next;
    logic             early_hit_next;
    logic             decided5_reg;
    logic             early_hit5_reg;
    logic             decided6_reg;
    logic             early_hit6_reg;
    logic [MUL_W-1:0] g_op;
    logic [MUL_W-1:0] l2_op;
    logic [MUL_W-1:0] t_op;
    logic [P_W-1:0]   gl2;
    logic [P_W-1:0]   tt;
    logic             overlap_next;
    logic             overlap_reg;
    sco_en_t          mul_en;

    // per-stage ready: a stage loads when empty or when its successor loads
    always_comb begin
        rdy[7] = !vld_reg[7] || m_ready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next = vld_reg;
        for (int k = 7; k >= 2; k--) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
        if (rdy[1]) begin
            vld_next[1] = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[1];
    assign m_valid = vld_reg[7];

    assign ctr[0]   = s_sphere_x;
    assign ctr[1]   = s_sphere_y;
    assign ctr[2]   = s_sphere_z;
    assign start[0] = s_seg_start_x;
    assign start[1] = s_seg_start_y;
    assign start[2] = s_seg_start_z;
    assign stop[0]  = s_seg_end_x;
    assign stop[1]  = s_seg_end_y;
    assign stop[2]  = s_seg_end_z;

    // stage 1
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                d_reg[i] <= DIFF_W'(stop[i]) - DIFF_W'(start[i]);
                w_reg[i] <= DIFF_W'(ctr[i]) - DIFF_W'(start[i]);
            end
            rsum_reg <= RSUM_W'(s_sphere_radius) + RSUM_W'(s_capsule_radius);
        end
    end

    // stage 2
    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                dd_reg[i] <= d_reg[i] * d_reg[i];
                wd_reg[i] <= w_reg[i] * d_reg[i];
                ww_reg[i] <= w_reg[i] * w_reg[i];
            end
            rr_reg <= rsum_reg * rsum_reg;
        end
    end

    // stage 3
    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            l2_reg  <= DOT_W'(dd_reg[0]) + DOT_W'(dd_reg[1]) + DOT_W'(dd_reg[2]);
            t_reg   <= DOT_W'(wd_reg[0]) + DOT_W'(wd_reg[1]) + DOT_W'(wd_reg[2]);
            wsq_reg <= DOT_W'(ww_reg[0]) + DOT_W'(ww_reg[1]) + DOT_W'(ww_reg[2]);
            rr3_reg <= rr_reg;
        end
    end

    // stage 4: g = ww - rr; |c - e|^2 = ww - 2t + l2
    always_comb begin
        wsq_ext = EXT_W'(wsq_reg);
        rr_ext  = EXT_W'(rr3_reg);
        t_ext   = EXT_W'(t_reg);
        l2_ext  = EXT_W'(l2_reg);
        g_next  = wsq_ext - rr_ext;
        ff_next = wsq_ext - (t_ext <<< 1) + l2_ext;
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            g_reg     <= g_next;
            ff_reg    <= ff_next;
            rr4_reg   <= rr_ext;
            l2_4_reg  <= l2_reg;
            t4_reg    <= t_reg;
            t_le0_reg <= (t_reg <= 0);
            t_ge_reg  <= (t_reg >= l2_reg);
        end
    end

    // stage 5: endpoint cases settle here; interior with ww <= rr always hits.
    // Otherwise (ww - rr) * l2 <= t * t decides, all terms positive.
    always_comb begin
        g_le0 = (g_reg <= 0);
        decided_next = t_le0_reg || t_ge_reg || g_le0;
        if (t_le0_reg) begin
            early_hit_next = g_le0;
        end else if (t_ge_reg) begin
            early_hit_next = (ff_reg <= rr4_reg);
        end else begin
            early_hit_next = 1'b1;
        end
        g_op  = g_reg[MUL_W-1:0];
        l2_op = MUL_W'(l2_4_reg[DOT_W-2:0]);
        t_op  = MUL_W'(t4_reg[DOT_W-2:0]);
    end

    assign mul_en.pp  = rdy[5];
    assign mul_en.sum = rdy[6];

    sco_wide_mul u_mul_gl2 (
        .aclk (aclk),
        .en   (mul_en),
        .a    (g_op),
        .b    (l2_op),
        .p    (gl2)
    );

    sco_wide_mul u_mul_tt (
        .aclk (aclk),
        .en   (mul_en),
        .a    (t_op),
        .b    (t_op),
        .p    (tt)
    );

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            decided5_reg   <= decided_next;
            early_hit5_reg <= early_hit_next;
        end
        if (rdy[6]) begin
            decided6_reg   <= decided5_reg;
            early_hit6_reg <= early_hit5_reg;
        end
    end

    // stage 7: output register
    assign overlap_next = decided6_reg ? early_hit6_reg : (gl2 <= tt);

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            overlap_reg <= overlap_next;
        end
    end

    assign m_overlap = overlap_reg;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the sphere/capsule overlap pipeline.
`timescale 1ns / 1ps

module tb_top;
    import sco_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int PREDICT      = -1;   // directed row checked against the predictor

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx, cy, cz;   // sphere center
        logic        [RAD_W-1:0]      rs;
        logic signed [COORD_BITS-1:0] ax, ay, az;   // segment start
        logic signed [COORD_BITS-1:0] bx, by, bz;   // segment end
        logic        [RAD_W-1:0]      rc;
    } query_t;

    typedef struct {
        query_t q;
        int     known;
    } dir_row_t;

    typedef enum int {Q_WILD, Q_LOCAL, Q_POINT, Q_TIGHT} qkind_t;

    logic                         aclk;
    logic                         aresetn          = 1'b0;
    logic                         s_valid          = 1'b0;
    logic                         s_ready;
    logic signed [COORD_BITS-1:0] s_sphere_x       = '0;
    logic signed [COORD_BITS-1:0] s_sphere_y       = '0;
    logic signed [COORD_BITS-1:0] s_sphere_z       = '0;
    logic        [RAD_W-1:0]      s_sphere_radius  = '0;
    logic signed [COORD_BITS-1:0] s_seg_start_x    = '0;
    logic signed [COORD_BITS-1:0] s_seg_start_y    = '0;
    logic signed [COORD_BITS-1:0] s_seg_start_z    = '0;
    logic signed [COORD_BITS-1:0] s_seg_end_x      = '0;
    logic signed [COORD_BITS-1:0] s_seg_end_y      = '0;
    logic signed [COORD_BITS-1:0] s_seg_end_z      = '0;
    logic        [RAD_W-1:0]      s_capsule_radius = '0;
    logic                         m_valid;
    logic                         m_ready          = 1'b0;
    logic                         m_overlap;

    logic     overlap_due [$];
    dir_row_t dir_rows [$];
    logic     due_ov;
    int       err_count   = 0;
    int       cycle_count = 0;
    bit       calm        = 1'b0;

    sphere_capsule_overlap_test u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sphere_x       (s_sphere_x),
        .s_sphere_y       (s_sphere_y),
        .s_sphere_z       (s_sphere_z),
        .s_sphere_radius  (s_sphere_radius),
        .s_seg_start_x    (s_seg_start_x),
        .s_seg_start_y    (s_seg_start_y),
        .s_seg_start_z    (s_seg_start_z),
        .s_seg_end_x      (s_seg_end_x),
        .s_seg_end_y      (s_seg_end_y),
        .s_seg_end_z      (s_seg_end_z),
        .s_capsule_radius (s_capsule_radius),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_overlap        (m_overlap)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic query_t mk_query(int cx, int cy, int cz, int rs,
                                        int ax, int ay, int az,
                                        int bx, int by, int bz, int rc);
        query_t q;
        q.cx = COORD_BITS'(cx); q.cy = COORD_BITS'(cy); q.cz = COORD_BITS'(cz);
        q.rs = RAD_W'(rs);
        q.ax = COORD_BITS'(ax); q.ay = COORD_BITS'(ay); q.az = COORD_BITS'(az);
        q.bx = COORD_BITS'(bx); q.by = COORD_BITS'(by); q.bz = COORD_BITS'(bz);
        q.rc = RAD_W'(rc);
        return q;
    endfunction

    // Exact closest-point test; interior case cross-multiplied by |d|^2.
    function automatic logic predict_overlap(query_t q);
        longint dx, dy, dz, wx, wy, wz, fx, fy, fz, rsum;
        logic signed [127:0] l2, t, ww, ff, rr;
        dx = longint'(q.bx) - longint'(q.ax);
        dy = longint'(q.by) - longint'(q.ay);
        dz = longint'(q.bz) - longint'(q.az);
        wx = longint'(q.cx) - longint'(q.ax);
        wy = longint'(q.cy) - longint'(q.ay);
        wz = longint'(q.cz) - longint'(q.az);
        fx = longint'(q.cx) - longint'(q.bx);
        fy = longint'(q.cy) - longint'(q.by);
        fz = longint'(q.cz) - longint'(q.bz);
        rsum = longint'(q.rs) + longint'(q.rc);
        l2 = 128'(dx * dx + dy * dy + dz * dz);
        t  = 128'(wx * dx + wy * dy + wz * dz);
        ww = 128'(wx * wx + wy * wy + wz * wz);
        ff = 128'(fx * fx + fy * fy + fz * fz);
        rr = 128'(rsum * rsum);
        if (t <= 0) begin
            return ww <= rr;
        end else if (l2 <= t) begin
            return ff <= rr;
        end else begin
            return (ww * l2 - t * t) <= (rr * l2);
        end
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic query_t rand_query(qkind_t kind);
        query_t q;
        int bx, by, bz, sp, rmax;
        if (kind == Q_WILD) begin
            q = mk_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
            return q;
        end
        sp   = (kind == Q_TIGHT) ? 40 : 2000;
        rmax = (kind == Q_TIGHT) ? 60 : 2000;
        bx = srand(16000);
        by = srand(16000);
        bz = srand(16000);
        q = mk_query(bx + srand(sp + sp / 2), by + srand(sp + sp / 2), bz + srand(sp + sp / 2),
                     $urandom_range(0, rmax),
                     bx + srand(sp), by + srand(sp), bz + srand(sp),
                     bx + srand(sp), by + srand(sp), bz + srand(sp),
                     $urandom_range(0, rmax));
        if (kind == Q_POINT) begin
            q.bx = q.ax; q.by = q.ay; q.bz = q.az;
        end
        return q;
    endfunction

    task automatic send_query(query_t q, logic want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_sphere_x       <= q.cx;
        s_sphere_y       <= q.cy;
        s_sphere_z       <= q.cz;
        s_sphere_radius  <= q.rs;
        s_seg_start_x    <= q.ax;
        s_seg_start_y    <= q.ay;
        s_seg_start_z    <= q.az;
        s_seg_end_x      <= q.bx;
        s_seg_end_y      <= q.by;
        s_seg_end_z      <= q.bz;
        s_capsule_radius <= q.rc;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        overlap_due.push_back(want);
    endtask

    task automatic add_row(int cx, int cy, int cz, int rs, int ax, int ay, int az,
                           int bx, int by, int bz, int rc, int known);
        dir_row_t row;
        row.q     = mk_query(cx, cy, cz, rs, ax, ay, az, bx, by, bz, rc);
        row.known = known;
        dir_rows.push_back(row);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (overlap_due.size() == 0) begin
                $display("%0t: unexpected item, expected none actual overlap=%0d",
                         $time, m_overlap);
                err_count++;
            end else begin
                due_ov = overlap_due.pop_front();
                if (m_overlap !== due_ov) begin
                    $display("%0t: overlap mismatch, expected %0d actual %0d",
                             $time, due_ov, m_overlap);
                    err_count++;
                end
            end
        end
    end

    // output back-pressure
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic   want;
        qkind_t kind;
        int     pick;

        // touching at zero distance, separated points, full-scale extremes
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_row(100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, 32767, 32767, 32767, 32767,
                32767, 32767, 32767, 32767, 0);
        add_row(0, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 32767, 1);
        // interior, exactly touching and one short
        add_row(0, 500, 0, 250, -1000, 0, 0, 1000, 0, 0, 250, 1);
        add_row(0, 500, 0, 249, -1000, 0, 0, 1000, 0, 0, 250, 0);
        add_row(0, 0, 500, 250, 1000, 0, 0, -1000, 0, 0, 250, 1);
        // past the start cap
        add_row(-300, 0, 0, 100, 0, 0, 0, 1000, 0, 0, 200, 1);
        add_row(-300, 0, 0, 100, 0, 0, 0, 1000, 0, 0, 199, 0);
        // past the end cap, and projection landing exactly on either end
        add_row(1300, 0, 0, 100, 0, 0, 0, 1000, 0, 0, 200, 1);
        add_row(1000, 400, 0, 200, 0, 0, 0, 1000, 0, 0, 200, 1);
        add_row(1000, 400, 0, 200, 0, 0, 0, 1000, 0, 0, 199, 0);
        add_row(0, 400, 0, 200, 0, 0, 0, 1000, 0, 0, 199, 0);
        add_row(-32768, -32768, -32768, 0, 32767, 32767, 32767,
                -32768, -32768, -32768, 0, 1);
        // full-length diagonal segments
        add_row(32767, -32768, 0, 0, -32768, -32768, -32768,
                32767, 32767, 32767, 0, PREDICT);
        add_row(0, 0, 0, 0, -32768, -32768, -32768, 32767, 32767, 32767, 0, PREDICT);
        add_row(0, 0, 0, 1, -32768, -32768, -32768, 32767, 32767, 32767, 0, PREDICT);
        add_row(-1, -1, -1, 32767, 32767, 32767, 32767,
                -32768, -32768, -32768, 32767, PREDICT);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            want = (dir_rows[i].known == PREDICT) ? predict_overlap(dir_rows[i].q)
                                                  : dir_rows[i].known[0];
            send_query(dir_rows[i].q, want);
        end

        // hold off until the pipe is empty
        s_valid <= 1'b0;
        while (overlap_due.size() != 0) @(posedge aclk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            query_t q;
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            pick = $urandom_range(0, 9);
            kind = (pick < 2) ? Q_WILD : (pick < 6) ? Q_LOCAL : (pick < 7) ? Q_POINT : Q_TIGHT;
            q = rand_query(kind);
            send_query(q, predict_overlap(q));
        end
        s_valid <= 1'b0;

        while (overlap_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sphere_capsule_overlap_test.f
rtl/sco_pkg.sv
rtl/sco_wide_mul.sv
rtl/sphere_capsule_overlap_test.sv
bench/tb_top.sv
